### sv/dqp_pkg.sv
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types, codes and the question type map for the DNS question parser.
// ----------------------------------------------------------------------------
package dqp_pkg;

  localparam int unsigned CfgW = 10;

  // register indexes
  localparam logic CFG_NAME_LIMIT  = 1'b0;
  localparam logic CFG_SHORT_LIMIT = 1'b1;

  // summary status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RESPONSE = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_OOB      = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;

  // question type class codes
  localparam logic [3:0] QT_A       = 4'd0;
  localparam logic [3:0] QT_NS      = 4'd1;
  localparam logic [3:0] QT_CNAME   = 4'd2;
  localparam logic [3:0] QT_SOA     = 4'd3;
  localparam logic [3:0] QT_PTR     = 4'd4;
  localparam logic [3:0] QT_MX      = 4'd5;
  localparam logic [3:0] QT_TXT     = 4'd6;
  localparam logic [3:0] QT_AAAA    = 4'd7;
  localparam logic [3:0] QT_SRV     = 4'd8;
  localparam logic [3:0] QT_UNKNOWN = 4'd9;

  localparam logic [7:0] DOT_CHAR = 8'd46;

  typedef struct packed {
    logic        last;
    logic [2:0]  status;
    logic [15:0] qclass_value;
    logic [3:0]  qtype_code;
    logic [15:0] qtype_value;
    logic [7:0]  name_char;
  } res_t;

  // results produced by one accepted byte, slot r0 first
  typedef struct packed {
    logic [1:0] count;
    res_t       r1;
    res_t       r0;
  } push_t;

  function automatic logic [3:0] classify_type(input logic [15:0] t);
    logic [3:0] c;
    unique case (t)
      16'd1:   c = QT_A;
      16'd2:   c = QT_NS;
      16'd5:   c = QT_CNAME;
      16'd6:   c = QT_SOA;
      16'd12:  c = QT_PTR;
      16'd15:  c = QT_MX;
      16'd16:  c = QT_TXT;
      16'd28:  c = QT_AAAA;
      16'd33:  c = QT_SRV;
      default: c = QT_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

### sv/dqp_parser.sv
// ----------------------------------------------------------------------------
// dqp_parser
// Per-byte parse step: header skip, label walk, type/class capture, summary.
// ----------------------------------------------------------------------------
module dqp_parser import dqp_pkg::*; #(
  parameter int unsigned PACKET_LIMIT = 512
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            take,
  input  logic [7:0]      byte_value,
  input  logic            last_byte,
  output push_t           push
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_LABEL  = 3'd2;
  localparam logic [2:0] PH_T0     = 3'd3;
  localparam logic [2:0] PH_T1     = 3'd4;
  localparam logic [2:0] PH_C0     = 3'd5;
  localparam logic [2:0] PH_C1     = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  localparam logic [9:0]  OFF_MAX = 10'd1023;
  localparam logic [9:0]  HDR_END = 10'd11;
  localparam logic [9:0]  QR_BYTE = 10'd2;
  localparam logic [16:0] LIMIT   = 17'(PACKET_LIMIT);

  logic [CfgW-1:0] name_limit;
  logic [CfgW-1:0] short_limit;

  logic [9:0]  byte_offset, byte_offset_next;
  logic [2:0]  parse_phase, parse_phase_next;
  logic [7:0]  label_remaining, label_remaining_next;
  logic        seen_first_label, seen_first_label_next;
  logic        is_response, is_response_next;
  logic [15:0] type_shift, type_shift_next;
  logic [15:0] class_shift, class_shift_next;
  logic [2:0]  error_code, error_code_next;

  logic        past_limit;
  logic        name_oob;
  logic [9:0]  off_inc;
  logic [2:0]  st;
  res_t        summ;

  assign past_limit = {7'd0, byte_offset} >= LIMIT;
  assign name_oob   = byte_offset >= name_limit;
  assign off_inc    = (byte_offset == OFF_MAX) ? byte_offset : byte_offset + 10'd1;

  always_comb begin
    byte_offset_next      = byte_offset;
    parse_phase_next      = parse_phase;
    label_remaining_next  = label_remaining;
    seen_first_label_next = seen_first_label;
    is_response_next      = is_response;
    type_shift_next       = type_shift;
    class_shift_next      = class_shift;
    error_code_next       = error_code;
    push                  = '0;
    st                    = ST_OK;
    summ                  = '0;

    if (take) begin
      if (!past_limit) begin
        unique case (parse_phase)
          PH_HEADER: begin
            if (byte_offset == QR_BYTE) begin
              is_response_next = byte_value[7];
            end
            if (byte_offset >= HDR_END) begin
              if (is_response) begin
                error_code_next  = ST_RESPONSE;
                parse_phase_next = PH_DONE;
              end else begin
                parse_phase_next = PH_LEN;
              end
            end
          end
          PH_LEN: begin
            if (name_oob) begin
              error_code_next  = ST_OOB;
              parse_phase_next = PH_DONE;
            end else if (byte_value == 8'd0) begin
              parse_phase_next = PH_T0;
            end else begin
              // dot goes out ahead of every label but the first
              if (seen_first_label) begin
                push.r0.name_char = DOT_CHAR;
                push.count        = 2'd1;
              end
              seen_first_label_next = 1'b1;
              label_remaining_next  = byte_value;
              parse_phase_next      = PH_LABEL;
            end
          end
          PH_LABEL: begin
            if (name_oob) begin
              error_code_next  = ST_OOB;
              parse_phase_next = PH_DONE;
            end else begin
              push.r0.name_char    = byte_value;
              push.count           = 2'd1;
              label_remaining_next = label_remaining - 8'd1;
              if (label_remaining == 8'd1) begin
                parse_phase_next = PH_LEN;
              end
            end
          end
          PH_T0, PH_T1: begin
            type_shift_next  = {type_shift[7:0], byte_value};
            parse_phase_next = parse_phase + 3'd1;
          end
          PH_C0, PH_C1: begin
            class_shift_next = {class_shift[7:0], byte_value};
            parse_phase_next = parse_phase + 3'd1;
          end
          default: ;
        endcase
      end

      byte_offset_next = off_inc;

      if (last_byte) begin
        priority if (off_inc < short_limit) begin
          st = ST_SHORT;
        end else if (error_code_next == ST_RESPONSE) begin
          st = ST_RESPONSE;
        end else if (error_code_next == ST_OOB) begin
          st = ST_OOB;
        end else if (parse_phase_next != PH_DONE) begin
          st = ST_TRUNC;
        end else begin
          st = ST_OK;
        end

        summ.last   = 1'b1;
        summ.status = st;
        if (st == ST_OK) begin
          summ.qtype_value  = type_shift_next;
          summ.qtype_code   = classify_type(type_shift_next);
          summ.qclass_value = class_shift_next;
        end else begin
          summ.qtype_code = QT_UNKNOWN;
        end

        if (push.count == 2'd0) begin
          push.r0 = summ;
        end else begin
          push.r1 = summ;
        end
        push.count = push.count + 2'd1;

        byte_offset_next      = '0;
        parse_phase_next      = PH_HEADER;
        label_remaining_next  = '0;
        seen_first_label_next = 1'b0;
        is_response_next      = 1'b0;
        type_shift_next       = '0;
        class_shift_next      = '0;
        error_code_next       = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit       <= CfgW'(512);
      short_limit      <= CfgW'(20);
      byte_offset      <= '0;
      parse_phase      <= PH_HEADER;
      label_remaining  <= '0;
      seen_first_label <= 1'b0;
      is_response      <= 1'b0;
      type_shift       <= '0;
      class_shift      <= '0;
      error_code       <= ST_OK;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NAME_LIMIT:  name_limit  <= cfg_data;
          CFG_SHORT_LIMIT: short_limit <= cfg_data;
          default: ;
        endcase
      end
      byte_offset      <= byte_offset_next;
      parse_phase      <= parse_phase_next;
      label_remaining  <= label_remaining_next;
      seen_first_label <= seen_first_label_next;
      is_response      <= is_response_next;
      type_shift       <= type_shift_next;
      class_shift      <= class_shift_next;
      error_code       <= error_code_next;
    end
  end

endmodule

### sv/dqp_out_fifo.sv
// ----------------------------------------------------------------------------
// dqp_out_fifo
// Four-entry result queue, up to two words written and one read per cycle.
// ----------------------------------------------------------------------------
module dqp_out_fifo import dqp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  m_tvalid,
  input  logic  m_tready,
  output res_t  head
);

  res_t       entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  // two free slots so any byte can be taken
  assign room     = count <= 3'd2;
  assign m_tvalid = count != 3'd0;
  assign pop      = m_tvalid && m_tready;
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push.count} - {2'b0, pop};
    end
  end

endmodule

### sv/dns_question_parser_top.sv
// ----------------------------------------------------------------------------
// dns_question_parser_top
// Streaming DNS question section parser with a four-word result queue.
// ----------------------------------------------------------------------------
// One packet byte is taken per clock. Each byte is parsed in the cycle it is
// accepted and its results (a name character or dot, and on the final byte a
// summary word) go into a four-entry queue in front of the master side. A
// byte is taken whenever the queue has two free slots, so with a free-running
// sink the block sustains one byte per cycle; a byte that yields both a
// character and the summary puts two words into the queue. The results of a
// byte are registered in the queue before they reach the master side.
module dns_question_parser_top import dqp_pkg::*; #(
  parameter int unsigned PACKET_LIMIT = 512
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,  // byte_value[7:0]
  input  logic            s_tlast,
  output logic            m_tvalid,
  input  logic            m_tready,
  // name_char[7:0], qtype_value[23:8], qtype_code[27:24],
  // qclass_value[43:28], status[46:44], zero pad[47]
  output logic [47:0]     m_tdata,
  output logic            m_tlast
);

  push_t push;
  res_t  head;
  logic  room;
  logic  take;

  assign s_tready = room;
  assign take     = s_tvalid && room;

  dqp_parser #(
    .PACKET_LIMIT(PACKET_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .byte_value(s_tdata),
    .last_byte (s_tlast),
    .push      (push)
  );

  dqp_out_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .head    (head)
  );

  assign m_tdata = {1'b0, head.status, head.qclass_value, head.qtype_code,
                    head.qtype_value, head.name_char};
  assign m_tlast = head.last;

endmodule

### tb/sv/dqp_question_checker.sv
// ----------------------------------------------------------------------------
// dqp_question_checker
// Watches the byte and result channels of the DNS question parser, keeps its
// own copy of the parse state and limits, predicts every result word and
// compares each accepted word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dqp_question_checker import dqp_pkg::*; #(
  parameter int unsigned PKT_LIMIT = 512
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            s_tvalid,
  input  logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            s_tlast,
  input  logic            m_tvalid,
  input  logic            m_tready,
  input  logic [47:0]     m_tdata,
  input  logic            m_tlast,
  output int              mismatches,
  output int              pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_HEADER, PH_LEN, PH_LABEL, PH_T0, PH_T1, PH_C0, PH_C1, PH_DONE
  } phase_e;

  localparam logic [9:0] HDR_LAST = 10'd11;
  localparam logic [9:0] OFFSET_SAT = 10'd1023;

  logic [9:0]  max_limit;
  logic [9:0]  min_length;
  logic [9:0]  offset;
  phase_e      phase;
  logic [7:0]  label_left;
  logic        seen_label;
  logic        qr_set;
  logic [15:0] qtype_acc;
  logic [15:0] qclass_acc;
  logic [2:0]  err_status;

  res_t predicted_words[$];

  function automatic logic [3:0] qtype_to_code(input logic [15:0] qt);
    case (qt)
      16'd1:   return QT_A;
      16'd2:   return QT_NS;
      16'd5:   return QT_CNAME;
      16'd6:   return QT_SOA;
      16'd12:  return QT_PTR;
      16'd15:  return QT_MX;
      16'd16:  return QT_TXT;
      16'd28:  return QT_AAAA;
      16'd33:  return QT_SRV;
      default: return QT_UNKNOWN;
    endcase
  endfunction

  task automatic clear_packet_state();
    offset     = '0;
    phase      = PH_HEADER;
    label_left = '0;
    seen_label = 1'b0;
    qr_set     = 1'b0;
    qtype_acc  = '0;
    qclass_acc = '0;
    err_status = ST_OK;
  endtask

  task automatic push_char(input logic [7:0] ch);
    res_t w;
    w = '0;
    w.name_char = ch;
    predicted_words.push_back(w);
  endtask

  task automatic parse_question_byte(input logic [7:0] b, input logic fin);
    res_t summary;
    logic [2:0] st;
    // bytes beyond the receive buffer are dropped but still counted
    if (int'(offset) < PKT_LIMIT) begin
      case (phase)
        PH_HEADER: begin
          if (offset == 10'd2) qr_set = b[7];
          if (offset >= HDR_LAST) begin
            if (qr_set) begin
              err_status = ST_RESPONSE;
              phase = PH_DONE;
            end else begin
              phase = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (offset >= max_limit) begin
            err_status = ST_OOB;
            phase = PH_DONE;
          end else if (b == 8'd0) begin
            phase = PH_T0;
          end else begin
            if (seen_label) push_char(DOT_CHAR);
            seen_label = 1'b1;
            label_left = b;
            phase = PH_LABEL;
          end
        end
        PH_LABEL: begin
          if (offset >= max_limit) begin
            err_status = ST_OOB;
            phase = PH_DONE;
          end else begin
            push_char(b);
            label_left = label_left - 8'd1;
            if (label_left == 8'd0) phase = PH_LEN;
          end
        end
        PH_T0: begin qtype_acc = {qtype_acc[7:0], b}; phase = PH_T1; end
        PH_T1: begin qtype_acc = {qtype_acc[7:0], b}; phase = PH_C0; end
        PH_C0: begin qclass_acc = {qclass_acc[7:0], b}; phase = PH_C1; end
        PH_C1: begin qclass_acc = {qclass_acc[7:0], b}; phase = PH_DONE; end
        default: ;
      endcase
    end
    if (offset != OFFSET_SAT) offset = offset + 10'd1;
    if (fin) begin
      if (offset < min_length) st = ST_SHORT;
      else if (err_status == ST_RESPONSE) st = ST_RESPONSE;
      else if (err_status == ST_OOB) st = ST_OOB;
      else if (phase != PH_DONE) st = ST_TRUNC;
      else st = ST_OK;
      summary = '0;
      summary.last = 1'b1;
      summary.status = st;
      if (st == ST_OK) begin
        summary.qtype_value  = qtype_acc;
        summary.qtype_code   = qtype_to_code(qtype_acc);
        summary.qclass_value = qclass_acc;
      end else begin
        summary.qtype_code = QT_UNKNOWN;
      end
      predicted_words.push_back(summary);
      clear_packet_state();
    end
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_word(input res_t got);
    res_t want;
    if (predicted_words.size() == 0) begin
      $error("unexpected word: name_char %0d status %0d last %0d",
             got.name_char, got.status, got.last);
      mismatches++;
      return;
    end
    want = predicted_words.pop_front();
    check_field("name_char", 16'(want.name_char), 16'(got.name_char));
    check_field("qtype_value", want.qtype_value, got.qtype_value);
    check_field("qtype_code", 16'(want.qtype_code), 16'(got.qtype_code));
    check_field("qclass_value", want.qclass_value, got.qclass_value);
    check_field("status", 16'(want.status), 16'(got.status));
    check_field("last", 16'(want.last), 16'(got.last));
  endtask

  always @(posedge clk) begin
    res_t got;
    if (rst) begin
      max_limit  = 10'd512;
      min_length = 10'd20;
      clear_packet_state();
      predicted_words.delete();
      mismatches = 0;
    end else begin
      // results are registered in the queue before they leave, so check before predicting
      if (m_tvalid && m_tready) begin
        got.name_char    = m_tdata[7:0];
        got.qtype_value  = m_tdata[23:8];
        got.qtype_code   = m_tdata[27:24];
        got.qclass_value = m_tdata[43:28];
        got.status       = m_tdata[46:44];
        got.last         = m_tlast;
        compare_word(got);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_NAME_LIMIT) max_limit = cfg_data;
        else min_length = cfg_data;
      end
      if (s_tvalid && s_tready) parse_question_byte(s_tdata, s_tlast);
    end
    pending_words = predicted_words.size();
  end

endmodule

### tb/sv/dns_question_parser_top_tb.sv
// ----------------------------------------------------------------------------
// dns_question_parser_top_tb
// Feeds DNS packets byte by byte into the question parser: a directed set of
// corner packets, then mostly well-formed queries with random names, types
// and classes mixed with responses, cut-off packets and noise, under several
// limit settings and random stalls on both sides. A checker module predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module dns_question_parser_top_tb;
  import dqp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PKT_LIMIT = 512;
  localparam int QUIET_LIMIT = 400;
  localparam logic [15:0] KNOWN_QTYPES [9] = '{16'd1, 16'd2, 16'd5, 16'd6,
    16'd12, 16'd15, 16'd16, 16'd28, 16'd33};

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic            cfg_index;
  logic [CfgW-1:0] cfg_data;
  logic            s_tvalid;
  logic            s_tready;
  logic [7:0]      s_tdata;
  logic            s_tlast;
  logic            m_tvalid;
  logic            m_tready;
  logic [47:0]     m_tdata;
  logic            m_tlast;

  int mismatches;
  int pending_words;
  int sent_bytes = 0;
  int quiet_cycles = 0;
  int sink_hold = 0;
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;

  logic [7:0] pkt[$];

  dns_question_parser_top #(.PACKET_LIMIT(PKT_LIMIT)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  dqp_question_checker #(.PKT_LIMIT(PKT_LIMIT)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .mismatches   (mismatches),
    .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(16, 40);
  endfunction

  // sink side: random stalls, no new ones started while sink_calm is set
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        m_tready = 1'b0;
        sink_hold--;
      end else begin
        m_tready = 1'b1;
        if (!sink_calm && $urandom_range(0, 99) < 20) sink_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = (!src_calm && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_packet();
    src_calm  = ($urandom_range(0, 3) == 0);
    sink_calm = ($urandom_range(0, 3) == 0);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  function automatic logic [15:0] pick_qtype();
    if ($urandom_range(0, 3) != 0) return KNOWN_QTYPES[$urandom_range(0, 8)];
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void build_query(input bit qr, input int labels,
                                      input int min_len, input int max_len,
                                      input logic [15:0] qt,
                                      input logic [15:0] qc, input int trail);
    logic [7:0] b;
    int len;
    pkt.delete();
    for (int i = 0; i < 12; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 2) b[7] = qr;
      pkt.push_back(b);
    end
    repeat (labels) begin
      len = $urandom_range(min_len, max_len);
      pkt.push_back(8'(len));
      repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
    end
    pkt.push_back(8'd0);
    pkt.push_back(qt[15:8]);
    pkt.push_back(qt[7:0]);
    pkt.push_back(qc[15:8]);
    pkt.push_back(qc[7:0]);
    repeat (trail) pkt.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void cut_packet(input int keep);
    while (pkt.size() > keep) void'(pkt.pop_back());
  endfunction

  function automatic logic [15:0] pick_qclass();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : 16'd1;
  endfunction

  task automatic random_packet();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      build_query(0, $urandom_range(1, 4), 1, 12, pick_qtype(), pick_qclass(),
                  $urandom_range(0, 3));
    end else if (r < 68) begin
      build_query(1, $urandom_range(1, 3), 1, 12, pick_qtype(), pick_qclass(),
                  $urandom_range(0, 3));
    end else if (r < 80) begin
      build_query(0, $urandom_range(1, 3), 1, 12, pick_qtype(), pick_qclass(), 0);
      cut_packet($urandom_range(1, pkt.size() - 1));
    end else if (r < 90) begin
      pkt.delete();
      repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom_range(0, 255)));
    end else if (r < 95) begin
      build_query(0, $urandom_range(1, 2), 30, 255, pick_qtype(), pick_qclass(), 0);
    end else begin
      // root name: the zero length byte right after the header
      build_query(0, 0, 1, 1, pick_qtype(), pick_qclass(), $urandom_range(0, 8));
    end
    send_packet();
  endtask

  task automatic run_random(input int budget);
    int stop;
    stop = sent_bytes + budget;
    while (sent_bytes < stop) random_packet();
  endtask

  // wait until every predicted word has left, then let the pipe drain
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limits(input logic [CfgW-1:0] max_v,
                            input logic [CfgW-1:0] min_v);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = CFG_NAME_LIMIT;
    cfg_data  = max_v;
    @(negedge clk);
    cfg_index = CFG_SHORT_LIMIT;
    cfg_data  = min_v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [15:0] qt;
    logic [15:0] qc;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_NAME_LIMIT;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed packets at the reset limits
    pkt = '{8'hFF};
    send_packet();
    build_query(1, 1, 3, 3, 16'd1, 16'd1, 0);
    cut_packet(11);
    send_packet();
    build_query(1, 2, 1, 5, 16'd1, 16'd1, 0);
    send_packet();
    for (int i = 0; i < 10; i++) begin
      qt = (i < 9) ? KNOWN_QTYPES[i] : 16'hFFFF;
      qc = (i == 0) ? 16'd0 : (i == 1) ? 16'hFFFF : 16'd1;
      build_query(0, 1 + i % 3, 1, 4, qt, qc, i % 2);
      send_packet();
    end
    // cut inside a label: last byte yields a character and the summary
    build_query(0, 1, 12, 12, 16'd1, 16'd1, 0);
    cut_packet(20);
    send_packet();
    // cut after the first class byte
    build_query(0, 2, 2, 6, 16'd16, 16'd1, 0);
    cut_packet(pkt.size() - 1);
    send_packet();
    build_query(0, 0, 1, 1, 16'd0, 16'd1, 3);
    send_packet();

    set_limits(10'd20, 10'd12);
    build_query(0, 1, 10, 10, 16'd1, 16'd1, 0);
    send_packet();
    build_query(0, 1, 3, 3, 16'd15, 16'd1, 0);
    send_packet();
    build_query(0, 1, 3, 3, 16'd1, 16'd1, 0);
    cut_packet(12);
    send_packet();
    cut_packet(11);
    send_packet();
    run_random(90);

    // length exactly at the short limit, then one byte below it
    set_limits(10'd512, 10'd30);
    build_query(0, 1, 12, 12, pick_qtype(), 16'd1, 0);
    send_packet();
    cut_packet(29);
    send_packet();
    run_random(50);

    set_limits(10'($urandom_range(20, 512)), 10'($urandom_range(12, 64)));
    run_random(90);

    set_limits(10'd512, 10'd20);
    run_random(90);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
sv/dqp_pkg.sv
sv/dqp_parser.sv
sv/dqp_out_fifo.sv
sv/dns_question_parser_top.sv
tb/sv/dqp_question_checker.sv
tb/sv/dns_question_parser_top_tb.sv
